// File: src/tccu_pkg.sv
// ----------------------------------------------------------------------------
// tccu_pkg: shared definitions for the ternary cube calculus unit
// Command and status codes, widths, controller/datapath interface structs
// and small helper functions on 2-bit cube positions.
// ----------------------------------------------------------------------------
`default_nettype none

package tccu_pkg;

  localparam int MAX_VARS = 16;
  localparam int NUM_POS  = 16;
  localparam int CUBE_W   = 2 * NUM_POS;
  localparam int CNT_W    = 5;

  localparam logic [2:0] CMD_A_IN_B    = 3'd0;
  localparam logic [2:0] CMD_B_IN_A    = 3'd1;
  localparam logic [2:0] CMD_OVERLAP   = 3'd2;
  localparam logic [2:0] CMD_MERGE     = 3'd3;
  localparam logic [2:0] CMD_GMERGE    = 3'd4;
  localparam logic [2:0] CMD_INTERSECT = 3'd5;
  localparam logic [2:0] CMD_SHARP     = 3'd6;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_DC_DIFF    = 2'd1;
  localparam logic [1:0] STAT_MULTI_DIFF = 2'd2;
  localparam logic [1:0] STAT_CONFLICT   = 2'd3;

  localparam logic [1:0] POS_DC = 2'b10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_input;
    logic load_single;
    logic load_mask;
    logic load_piece;
  } tccu_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic multi;
    logic last_piece;
  } tccu_sts_t;

  // Map both don't-care codes onto one code
  function automatic logic [1:0] canon_pos(input logic [1:0] v);
    return v[1] ? POS_DC : v;
  endfunction

  // True when at least two bits are set
  function automatic logic two_or_more(input logic [NUM_POS-1:0] v);
    return (v & (v - NUM_POS'(1))) != '0;
  endfunction

endpackage

`default_nettype wire

// File: src/ternary_cube_calculus_unit_core.sv
// ----------------------------------------------------------------------------
// ternary_cube_calculus_unit_core: ternary cube calculus unit, top level
// Containment, overlap, adjacent and generalized merge, intersection and
// sharp difference on two cubes of up to sixteen 2-bit positions.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | cmd, cube_a, cube_b
//  out     | out_valid / out_ready  | result_cube, test_flag, status,
//          |                        | empty_result, last
//  cfg     | psel/penable/pwrite    | paddr, pwdata, prdata (var_count at 0x0)
//
//  A request is captured, then evaluated into the output register when
//  the output is free; sharp evaluation loads the pending mask instead.
//  Sharp then emits one piece per cycle while the output is not stalled,
//  a rate set by the single output register. One request is in flight
//  at a time. Reset (rst, synchronous) empties the output register and
//  sets var_count to 16. A stalled output holds every piece in place.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_cube_calculus_unit_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  cmd,
  input  wire logic [tccu_pkg::CUBE_W-1:0] cube_a,
  input  wire logic [tccu_pkg::CUBE_W-1:0] cube_b,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [tccu_pkg::CUBE_W-1:0] result_cube,
  output logic                             test_flag,
  output logic      [1:0]                  status,
  output logic                             empty_result,
  output logic                             last,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [tccu_pkg::CNT_W-1:0] var_count;
  logic                       cfg_write;
  tccu_pkg::tccu_ctl_t        ctl;
  tccu_pkg::tccu_sts_t        sts;

  // Single register: paddr[2] clear selects var_count, the rest is unmapped
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? 32'd0 : {{(32 - tccu_pkg::CNT_W){1'b0}}, var_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count <= tccu_pkg::CNT_W'(16);
    end else if (cfg_write && !paddr[2]) begin
      var_count <= pwdata[tccu_pkg::CNT_W-1:0];
    end
  end

  // Sequencing: capture, evaluate, then emit sharp pieces one per cycle while the output is free
  tccu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Operand registers, evaluation logic, pending mask and output register
  tccu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .cube_a       (cube_a),
    .cube_b       (cube_b),
    .var_count    (var_count),
    .result_cube  (result_cube),
    .test_flag    (test_flag),
    .status       (status),
    .empty_result (empty_result),
    .last         (last)
  );

endmodule

`default_nettype wire

// File: src/tccu_ctrl.sv
// ----------------------------------------------------------------------------
// tccu_ctrl: sequencing controller for the cube calculus unit
// Accepts one request at a time, orders evaluation and emission of results
// into the output register, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tccu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tccu_pkg::tccu_ctl_t      ctl,
  input  wire tccu_pkg::tccu_sts_t sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_SHARP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load_input = 1'b1;
          state_next     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (slot_free) begin
          if (sts.multi) begin
            ctl.load_mask = 1'b1;
            state_next    = ST_SHARP;
          end else begin
            ctl.load_single = 1'b1;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_SHARP: begin
        if (slot_free) begin
          ctl.load_piece = 1'b1;
          if (sts.last_piece) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_single || ctl.load_piece) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_EVAL))
    else $error("accepted request did not move to evaluation");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && slot_free && !sts.multi) |=> (out_valid && state == ST_IDLE))
    else $error("single result not presented");

  a_last_piece: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHARP && slot_free && sts.last_piece) |=> (out_valid && state == ST_IDLE))
    else $error("final sharp piece did not end the command");
`endif

endmodule

`default_nettype wire

// File: src/tccu_dp.sv
// ----------------------------------------------------------------------------
// tccu_dp: datapath of the cube calculus unit
// Holds the accepted cubes, evaluates tests, merges and sharp, keeps the
// mask of sharp positions still to emit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccu_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tccu_pkg::tccu_ctl_t           ctl,
  output tccu_pkg::tccu_sts_t                sts,
  input  wire logic [2:0]                    cmd,
  input  wire logic [tccu_pkg::CUBE_W-1:0]   cube_a,
  input  wire logic [tccu_pkg::CUBE_W-1:0]   cube_b,
  input  wire logic [tccu_pkg::CNT_W-1:0]    var_count,
  output logic      [tccu_pkg::CUBE_W-1:0]   result_cube,
  output logic                               test_flag,
  output logic      [1:0]                    status,
  output logic                               empty_result,
  output logic                               last
);

  localparam int NP = tccu_pkg::NUM_POS;
  localparam int CW = tccu_pkg::CUBE_W;

  logic [2:0]                  held_cmd;
  logic [CW-1:0]               held_first;
  logic [CW-1:0]               held_second;
  logic [NP-1:0]               pending_positions;

  logic [tccu_pkg::CNT_W-1:0]  n_used;
  logic [NP-1:0]               used;
  logic [NP-1:0]               dc_diff;
  logic [NP-1:0]               const_diff;
  logic [NP-1:0]               fail_ab;
  logic [NP-1:0]               fail_ba;
  logic [NP-1:0]               piece_mask;
  logic [CW-1:0]               canon_a;
  logic [CW-1:0]               merge_cube;
  logic [CW-1:0]               piece_cube;
  logic [NP-1:0]               piece_sel;
  logic [NP-1:0]               pending_rest;
  logic [NP-1:0]               dc_first;
  logic [NP-1:0]               before_dc;
  logic [1:0]                  merge_status;

  logic [CW-1:0]               s_cube;
  logic                        s_flag;
  logic [1:0]                  s_status;
  logic                        s_empty;

  assign n_used = (var_count > tccu_pkg::CNT_W'(tccu_pkg::MAX_VARS))
                ? tccu_pkg::CNT_W'(tccu_pkg::MAX_VARS) : var_count;

  assign piece_sel    = pending_positions & (~pending_positions + NP'(1));
  assign pending_rest = pending_positions & ~piece_sel;

  // Per-position classification, all positions side by side
  always_comb begin
    logic [1:0] pa;
    logic [1:0] pb;
    logic       eq;
    for (int i = 0; i < NP; i++) begin
      pa            = tccu_pkg::canon_pos(held_first[2*i +: 2]);
      pb            = tccu_pkg::canon_pos(held_second[2*i +: 2]);
      eq            = (pa == pb);
      used[i]       = (tccu_pkg::CNT_W'(i) < n_used);
      dc_diff[i]    = used[i] && !eq && (pa[1] || pb[1]);
      const_diff[i] = used[i] && !eq && !pa[1] && !pb[1];
      fail_ab[i]    = used[i] && !eq && !pb[1];
      fail_ba[i]    = used[i] && !eq && !pa[1];
      piece_mask[i] = used[i] && pa[1] && !pb[1];
      canon_a[2*i +: 2] = used[i] ? pa : 2'b00;
      if (!used[i]) begin
        merge_cube[2*i +: 2] = 2'b00;
      end else if (eq) begin
        merge_cube[2*i +: 2] = pa;
      end else if (pa[1] || pb[1]) begin
        merge_cube[2*i +: 2] = pa[1] ? pb : pa;
      end else begin
        merge_cube[2*i +: 2] = tccu_pkg::POS_DC;
      end
      piece_cube[2*i +: 2] = piece_sel[i] ? {1'b0, ~pb[0]} : canon_a[2*i +: 2];
    end
  end

  // Adjacent merge: the earlier of a don't-care difference and the second
  // constant difference decides the status
  assign dc_first  = dc_diff & (~dc_diff + NP'(1));
  assign before_dc = dc_first - NP'(1);

  always_comb begin
    merge_status = tccu_pkg::STAT_OK;
    unique case (held_cmd)
      tccu_pkg::CMD_MERGE: begin
        if (dc_diff != '0 && !tccu_pkg::two_or_more(const_diff & before_dc)) begin
          merge_status = tccu_pkg::STAT_DC_DIFF;
        end else if (tccu_pkg::two_or_more(const_diff)) begin
          merge_status = tccu_pkg::STAT_MULTI_DIFF;
        end
      end
      tccu_pkg::CMD_GMERGE: begin
        if (tccu_pkg::two_or_more(const_diff)) begin
          merge_status = tccu_pkg::STAT_MULTI_DIFF;
        end
      end
      tccu_pkg::CMD_INTERSECT: begin
        if (const_diff != '0) begin
          merge_status = tccu_pkg::STAT_CONFLICT;
        end
      end
      default: begin
        merge_status = tccu_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    s_cube   = '0;
    s_flag   = 1'b0;
    s_status = tccu_pkg::STAT_OK;
    s_empty  = 1'b0;
    unique case (held_cmd) inside
      tccu_pkg::CMD_A_IN_B:  s_flag = (fail_ab == '0);
      tccu_pkg::CMD_B_IN_A:  s_flag = (fail_ba == '0);
      tccu_pkg::CMD_OVERLAP: s_flag = (const_diff == '0);
      tccu_pkg::CMD_MERGE, tccu_pkg::CMD_GMERGE, tccu_pkg::CMD_INTERSECT: begin
        s_status = merge_status;
        s_cube   = (merge_status == tccu_pkg::STAT_OK) ? merge_cube : '0;
      end
      tccu_pkg::CMD_SHARP: begin
        if (fail_ab == '0) begin
          s_empty = 1'b1;
        end else if (const_diff != '0) begin
          s_cube = canon_a;
        end else begin
          s_empty = (piece_mask == '0);
        end
      end
      default: begin
        s_cube = '0;
      end
    endcase
  end

  assign sts.multi = (held_cmd == tccu_pkg::CMD_SHARP) && (fail_ab != '0)
                   && (const_diff == '0) && (piece_mask != '0);
  assign sts.last_piece = (pending_rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_positions <= '0;
      held_cmd          <= '0;
      held_first        <= '0;
      held_second       <= '0;
    end else begin
      if (ctl.load_mask) begin
        pending_positions <= piece_mask;
      end else if (ctl.load_piece) begin
        pending_positions <= pending_rest;
      end
      if (ctl.load_input) begin
        held_cmd    <= cmd;
        held_first  <= cube_a;
        held_second <= cube_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_single) begin
      result_cube  <= s_cube;
      test_flag    <= s_flag;
      status       <= s_status;
      empty_result <= s_empty;
      last         <= 1'b1;
    end else if (ctl.load_piece) begin
      result_cube  <= piece_cube;
      test_flag    <= 1'b0;
      status       <= tccu_pkg::STAT_OK;
      empty_result <= 1'b0;
      last         <= sts.last_piece;
    end
  end

`ifndef SYNTH
  a_mask_loaded: assert property (@(posedge clk) disable iff (rst)
    ctl.load_mask |=> (pending_positions != '0))
    else $error("sharp mask loaded empty");

  a_one_piece: assert property (@(posedge clk) disable iff (rst)
    ctl.load_piece |=>
      ($countones(pending_positions) == $countones($past(pending_positions)) - 1))
    else $error("sharp emission did not retire exactly one position");
`endif

endmodule

`default_nettype wire

// File: tb/tccu_result_checker.sv
// ----------------------------------------------------------------------------
// tccu_result_checker: result checker for the ternary cube calculus unit
// Snoops the request, result and configuration channels, predicts the
// result items of every accepted request and compares them in order.
// ----------------------------------------------------------------------------

module tccu_result_checker
  import tccu_pkg::*;
#(
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        cmd,
  input  logic [CUBE_W-1:0] cube_a,
  input  logic [CUBE_W-1:0] cube_b,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CUBE_W-1:0] result_cube,
  input  logic              test_flag,
  input  logic [1:0]        status,
  input  logic              empty_result,
  input  logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                cubes_pending,
  output int                results_checked
);

  typedef struct packed {
    logic [CUBE_W-1:0] cube;
    logic              flag;
    logic [1:0]        code;
    logic              is_empty;
    logic              is_last;
  } cube_result_t;

  cube_result_t awaited_cubes[$];
  logic [4:0]   cfg_var_count = 5'd16;

  // Position i with both don't-care codes folded onto one
  function automatic logic [1:0] pos_at(input logic [CUBE_W-1:0] c, input int i);
    logic [1:0] v;
    v = c[2*i +: 2];
    return v[1] ? POS_DC : v;
  endfunction

  // x lies within y: y is don't-care or equal to x at every position
  function automatic logic lies_within(input logic [CUBE_W-1:0] x, y, input int n);
    for (int i = 0; i < n; i++)
      if (pos_at(y, i) != POS_DC && pos_at(x, i) != pos_at(y, i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic cubes_meet(input logic [CUBE_W-1:0] x, y, input int n);
    for (int i = 0; i < n; i++)
      if (pos_at(x, i) != POS_DC && pos_at(y, i) != POS_DC && pos_at(x, i) != pos_at(y, i))
        return 1'b0;
    return 1'b1;
  endfunction

  // Append one predicted item at the tail of the awaited list
  function automatic void queue_result(input cube_result_t r);
    awaited_cubes = {awaited_cubes, r};
  endfunction

  function automatic void compute_cube_results(input logic [2:0] c,
                                               input logic [CUBE_W-1:0] a, b);
    cube_result_t      res;
    cube_result_t      sharp_pieces[$];
    logic [CUBE_W-1:0] merged;
    logic [CUBE_W-1:0] a_canon;
    logic [1:0]        st;
    logic [1:0]        p;
    logic [1:0]        q;
    logic [1:0]        v;
    int                n;
    int                diffs;
    n = (cfg_var_count > 5'd16) ? 16 : int'(cfg_var_count);
    res = '0;
    res.is_last = 1'b1;
    case (c)
      CMD_A_IN_B:    res.flag = lies_within(a, b, n);
      CMD_B_IN_A:    res.flag = lies_within(b, a, n);
      CMD_OVERLAP:   res.flag = cubes_meet(a, b, n);
      CMD_MERGE, CMD_GMERGE, CMD_INTERSECT: begin
        merged = '0;
        st = STAT_OK;
        diffs = 0;
        // first error met from position 0 upward decides the status
        for (int i = 0; i < n && st == STAT_OK; i++) begin
          p = pos_at(a, i);
          q = pos_at(b, i);
          v = p;
          if (p != q) begin
            if (p == POS_DC || q == POS_DC) begin
              if (c == CMD_MERGE) st = STAT_DC_DIFF;
              else v = (p != POS_DC) ? p : q;
            end else if (c == CMD_INTERSECT) begin
              st = STAT_CONFLICT;
            end else begin
              diffs++;
              if (diffs >= 2) st = STAT_MULTI_DIFF;
              v = POS_DC;
            end
          end
          merged[2*i +: 2] = v;
        end
        res.code = st;
        res.cube = (st == STAT_OK) ? merged : '0;
      end
      CMD_SHARP: begin
        a_canon = '0;
        for (int i = 0; i < n; i++) a_canon[2*i +: 2] = pos_at(a, i);
        if (lies_within(a, b, n)) begin
          res.is_empty = 1'b1;
        end else if (!cubes_meet(a, b, n)) begin
          res.cube = a_canon;
        end else begin
          // one piece per position where a is open and b is fixed
          for (int i = 0; i < n; i++) begin
            p = pos_at(a, i);
            q = pos_at(b, i);
            if (p == POS_DC && q != POS_DC) begin
              res = '0;
              res.cube = a_canon;
              res.cube[2*i +: 2] = q ^ 2'b01;
              sharp_pieces = {sharp_pieces, res};
            end
          end
          if (sharp_pieces.size() == 0) begin
            res = '0;
            res.is_empty = 1'b1;
          end else begin
            res = sharp_pieces.pop_back();
            foreach (sharp_pieces[j]) queue_result(sharp_pieces[j]);
          end
          res.is_last = 1'b1;
        end
      end
      default: ;
    endcase
    queue_result(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [CUBE_W-1:0] got,
                                 input logic [CUBE_W-1:0] want);
    if (mismatches < 40)
      $display("[%0t] result %0d: %s got %h, expected %h",
               $time, results_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    cube_result_t want;
    if (awaited_cubes.size() == 0) begin
      report_mismatch("result with nothing awaited, cube", result_cube, '0);
      return;
    end
    want = awaited_cubes.pop_front();
    if (result_cube !== want.cube) report_mismatch("result_cube", result_cube, want.cube);
    if (test_flag !== want.flag)
      report_mismatch("test_flag", CUBE_W'(test_flag), CUBE_W'(want.flag));
    if (status !== want.code)
      report_mismatch("status", CUBE_W'(status), CUBE_W'(want.code));
    if (empty_result !== want.is_empty)
      report_mismatch("empty_result", CUBE_W'(empty_result), CUBE_W'(want.is_empty));
    if (last !== want.is_last)
      report_mismatch("last", CUBE_W'(last), CUBE_W'(want.is_last));
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_var_count = 5'd16;
      awaited_cubes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
        cfg_var_count = pwdata[4:0];
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) compute_cube_results(cmd, cube_a, cube_b);
    end
    cubes_pending = awaited_cubes.size();
  end

endmodule

// File: tb/ternary_cube_calculus_unit_core_tb.sv
// ----------------------------------------------------------------------------
// ternary_cube_calculus_unit_core_tb: testbench for the cube calculus unit
// Drives directed and random cube pairs under every command through several
// var_count settings and idling mixes; a checker beside the block predicts
// and compares each result item.
// ----------------------------------------------------------------------------

module ternary_cube_calculus_unit_core_tb;
  import tccu_pkg::*;

  localparam logic [2:0] VAR_COUNT_ADDR  = 3'd0;
  localparam logic [2:0] CMD_NONE        = 3'd7;  // unassigned command code
  localparam int         LIMIT_CYCLES    = 400000;
  localparam int         SETTLE_CYCLES   = 24;    // covers a full sixteen-piece sharp
  localparam int         HOLD_OFF_CYCLES = 120;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [2:0]        cmd       = '0;
  logic [CUBE_W-1:0] cube_a    = '0;
  logic [CUBE_W-1:0] cube_b    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CUBE_W-1:0] result_cube;
  logic              test_flag;
  logic [1:0]        status;
  logic              empty_result;
  logic              last;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [2:0]        paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int         mismatches;
  int         cubes_pending;
  int         results_checked;
  int         requests_sent  = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  logic       hold_off_armed = 1'b0;
  logic [4:0] cur_var_count  = 5'd16;

  ternary_cube_calculus_unit_core u_top (.*);

  tccu_result_checker #(.CFG_ADDR(VAR_COUNT_ADDR)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: count cycles and give up on a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random backpressure; on request, hold off for a long stretch so the
  // output register fills and the block stalls its request channel.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one request and hold it until accepted. Valid stays high across
  // back-to-back requests; drop it only when the sender decides to idle.
  task automatic send_request(input logic [2:0] c, input logic [CUBE_W-1:0] a, b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    cube_a   <= a;
    cube_b   <= b;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drop valid and wait until every awaited result has come back, then let a
  // sharp's worth of cycles pass so the block is surely idle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cubes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_var_count(input logic [4:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VAR_COUNT_ADDR;
    pwdata  <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_var_count = v;
  endtask

  task automatic start_phase(input logic [4:0] vc, input int s_pct, input int r_pct);
    wait_for_drain();
    write_var_count(vc);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  // Build a cube pair. Mostly b starts as a copy of a (don't-care codes
  // reshuffled) and then takes a few edits inside the used positions, which
  // gives single differences, don't-care clashes and conflicts. Sharp pairs
  // often get many open positions in a against constants in b, for long
  // piece trains. A fifth of the pairs are unrelated noise.
  task automatic make_cubes(input logic [2:0] c, output logic [CUBE_W-1:0] a,
                            output logic [CUBE_W-1:0] b);
    int style;
    int span;
    int p;
    a = $urandom;
    b = a;
    span = (cur_var_count == 5'd0 || cur_var_count > 5'd16) ? 16 : int'(cur_var_count);
    style = $urandom_range(0, 9);
    if (style < 2) begin
      b = $urandom;
    end else begin
      for (int i = 0; i < 16; i++)
        if (b[2*i+1]) b[2*i] = 1'($urandom_range(0, 1));
      if (c == CMD_SHARP && style > 4) begin
        for (int i = 0; i < span; i++)
          if ($urandom_range(0, 1)) begin
            a[2*i +: 2] = {1'b1, 1'($urandom_range(0, 1))};
            b[2*i +: 2] = 2'($urandom_range(0, 1));
          end
      end
      repeat ($urandom_range(0, 2)) begin
        p = $urandom_range(0, span - 1);
        b[2*p +: 2] = 2'($urandom);
      end
    end
  endtask

  task automatic run_random(input int count);
    logic [2:0]        c;
    logic [CUBE_W-1:0] a;
    logic [CUBE_W-1:0] b;
    repeat (count) begin
      c = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) c = CMD_SHARP;
      make_cubes(c, a, b);
      send_request(c, a, b);
    end
  endtask

  // Edge cases at the reset width of sixteen positions
  task automatic run_directed();
    send_request(CMD_A_IN_B,    32'h0000_0000, 32'h0000_0000);
    send_request(CMD_A_IN_B,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_A_IN_B,    32'hFFFF_FFFF, 32'h5555_5555);
    send_request(CMD_B_IN_A,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_OVERLAP,   32'h5555_5555, 32'h0000_0000);
    send_request(CMD_OVERLAP,   32'hAAAA_AAAA, 32'h5555_5555);
    send_request(CMD_OVERLAP,   32'hAAAA_AAAA, 32'hFFFF_FFFF);
    // adjacent merge: clean, one difference, don't-care clash, two differences
    send_request(CMD_MERGE,     32'h0000_0000, 32'h0000_0000);
    send_request(CMD_MERGE,     32'h0000_0000, 32'h0000_0001);
    send_request(CMD_MERGE,     32'h0000_0000, 32'h0000_0002);
    send_request(CMD_MERGE,     32'h0000_0000, 32'h0000_0005);
    send_request(CMD_MERGE,     32'h0000_0002, 32'h0000_0005);
    // generalized merge resolves don't-care against a constant
    send_request(CMD_GMERGE,    32'h0000_0002, 32'h0000_0001);
    send_request(CMD_GMERGE,    32'h0000_0000, 32'h0000_0014);
    send_request(CMD_GMERGE,    32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_INTERSECT, 32'hFFFF_FFFF, 32'h5555_5555);
    send_request(CMD_INTERSECT, 32'h0000_0000, 32'h4000_0000);
    send_request(CMD_INTERSECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // sharp: a within b, disjoint, sixteen pieces twice, eight pieces
    send_request(CMD_SHARP,     32'h5555_5555, 32'hFFFF_FFFF);
    send_request(CMD_SHARP,     32'h0000_0000, 32'h0000_0001);
    send_request(CMD_SHARP,     32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_SHARP,     32'hAAAA_AAAA, 32'h5555_5555);
    send_request(CMD_SHARP,     32'h0000_FFFF, 32'h0000_0000);
    send_request(CMD_NONE,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  initial begin
    int saved_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Heavy receiver idling first
    send_idle_pct = 33;
    recv_idle_pct = 76;
    run_directed();
    run_random(60);
    start_phase(5'd1, 33, 76);
    run_random(30);
    start_phase(5'd31, 33, 76);
    run_random(40);

    // Heavy sender idling next, starting with no positions in use at all
    start_phase(5'd0, 76, 33);
    run_random(20);
    start_phase(5'($urandom_range(2, 15)), 76, 33);
    run_random(60);
    start_phase(5'd16, 76, 33);
    run_random(40);

    // Stall the output for a long stretch while sharps keep coming
    hold_off_armed = 1'b1;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    repeat (12) begin
      send_request(CMD_SHARP, 32'hFFFF_FFFF, 32'($urandom));
    end
    send_idle_pct = saved_pct;

    // Full rate on both sides
    start_phase(5'($urandom_range(17, 30)), 0, 0);
    run_random(50);
    start_phase(5'd5, 0, 0);
    run_random(40);

    wait_for_drain();
    $display("Covered %0d requests and %0d result items over all commands and codes",
             requests_sent, results_checked);
    $display("var_count ran 0, 1, 5, 16, 31 and random values; idling mixes and a long stall");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
